/* rtl/flsa_pkg.sv */
// Shared package for the free-list slot allocator.
// Holds the default slot count, field widths, request and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package flsa_pkg;

    localparam int SLOTS_DEF = 256;
    localparam int SLOT_W    = 16;
    localparam int GRANT_W   = 8;
    localparam int STATUS_W  = 2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_OOM    = 2'd1,
        ST_DOUBLE = 2'd2,
        ST_BOUNDS = 2'd3
    } status_t;

endpackage

`default_nettype wire

/* rtl/flsa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds until the next read enable. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module flsa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/free_list_slot_allocator.sv */
// Top level of the free-list slot allocator: control sequencer, head register
// and the next-index RAM (flsa_ram). Uses flsa_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  cfg     | in        | cfg_valid/cfg_ready | cfg_safety
//  s       | in        | s_valid/s_ready     | s_kind, s_slot
//  m       | out       | m_valid/m_ready     | m_granted_slot, m_status
//
// Allocate: the head's successor is read from the next-index RAM, then the head is updated.
// Free: with safety off or an out-of-range slot, no list walk; with safety on, the
// list is first walked from the head for the slot, reading at most SLOTS entries.
// The walk shares the single RAM read port.
// After reset an init sweep writes the chain 0..SLOTS-1 into the RAM,
// with s_ready low throughout. Config writes are taken at any time.
// One request in flight; a new one is taken while the last result waits on m_ready.
`timescale 1ns / 1ps
`default_nettype none

module free_list_slot_allocator
    import flsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_safety,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_kind,
    input  wire logic [SLOT_W-1:0]   s_slot,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic      [GRANT_W-1:0]  m_granted_slot,
    output logic      [STATUS_W-1:0] m_status
);

    localparam int IW = $clog2(SLOTS + 1);   // index incl. null code
    localparam int AW = $clog2(SLOTS);
    localparam logic [IW-1:0] NULL_IDX  = IW'(SLOTS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

    typedef enum logic [4:0] {
        S_INIT    = 5'b00001,
        S_IDLE    = 5'b00010,
        S_WALK    = 5'b00100,
        S_WALK_RD = 5'b01000,
        S_FINISH  = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_POP  = 2'd1,
        ACT_PUSH = 2'd2
    } act_t;

    state_t             state_reg, state_next;
    act_t               act_reg, act_next;
    status_t            res_reg, res_next;
    logic [IW-1:0]      head_reg, head_next;
    logic [IW-1:0]      cur_reg, cur_next;
    logic [IW-1:0]      cnt_reg, cnt_next;
    logic [IW-1:0]      slot_reg, slot_next;
    logic [AW-1:0]      init_reg, init_next;
    logic               safety_reg, safety_next;
    logic               m_valid_reg, m_valid_next;
    logic [GRANT_W-1:0] m_grant_reg, m_grant_next;
    status_t            m_status_reg, m_status_next;

    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [IW-1:0]      ram_wr_data;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [IW-1:0]      ram_rd_data;

    logic               slot_in_range;
    logic               head_null;
    logic               out_free;

    flsa_ram #(
        .WIDTH (IW),
        .DEPTH (SLOTS)
    ) u_next_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign slot_in_range = (32'(s_slot) < 32'(SLOTS));
    assign head_null     = (head_reg >= NULL_IDX);
    assign out_free      = !m_valid_reg || m_ready;

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_granted_slot = m_grant_reg;
    assign m_status       = m_status_reg;

    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        res_next      = res_reg;
        head_next     = head_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        slot_next     = slot_reg;
        init_next     = init_reg;
        safety_next   = safety_reg;
        m_valid_next  = m_valid_reg;
        m_grant_next  = m_grant_reg;
        m_status_next = m_status_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = '0;
        ram_wr_data   = '0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = '0;

        if (cfg_valid) begin
            safety_next = cfg_safety;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = init_reg;
                ram_wr_data = IW'(init_reg) + IW'(1);
                init_next   = init_reg + AW'(1);
                if (init_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    slot_next = IW'(s_slot);
                    if (s_kind == KIND_ALLOC) begin
                        if (head_null) begin
                            res_next   = ST_OOM;
                            act_next   = ACT_NONE;
                        end else begin
                            // successor of the head arrives next cycle
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = head_reg[AW-1:0];
                            res_next    = ST_OK;
                            act_next    = ACT_POP;
                        end
                        state_next = S_FINISH;
                    end else if (!slot_in_range) begin
                        res_next   = ST_BOUNDS;
                        act_next   = ACT_NONE;
                        state_next = S_FINISH;
                    end else if (safety_reg) begin
                        cur_next   = head_reg;
                        cnt_next   = '0;
                        state_next = S_WALK;
                    end else begin
                        res_next   = ST_OK;
                        act_next   = ACT_PUSH;
                        state_next = S_FINISH;
                    end
                end
            end
            S_WALK: begin
                // bounded walk: a list looped by unchecked frees still ends
                if (cur_reg >= NULL_IDX || cnt_reg == NULL_IDX) begin
                    res_next   = ST_OK;
                    act_next   = ACT_PUSH;
                    state_next = S_FINISH;
                end else if (cur_reg == slot_reg) begin
                    res_next   = ST_DOUBLE;
                    act_next   = ACT_NONE;
                    state_next = S_FINISH;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = cur_reg[AW-1:0];
                    cnt_next    = cnt_reg + IW'(1);
                    state_next  = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                cur_next   = ram_rd_data;
                state_next = S_WALK;
            end
            S_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_reg;
                    m_grant_next  = (act_reg == ACT_POP) ? GRANT_W'(head_reg) : '0;
                    case (act_reg)
                        ACT_POP: begin
                            head_next = ram_rd_data;
                        end
                        ACT_PUSH: begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = slot_reg[AW-1:0];
                            ram_wr_data = head_reg;
                            head_next   = slot_reg;
                        end
                        default: begin
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            act_reg     <= ACT_NONE;
            head_reg    <= '0;
            init_reg    <= '0;
            safety_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            act_reg     <= act_next;
            head_reg    <= head_next;
            init_reg    <= init_next;
            safety_reg  <= safety_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg      <= res_next;
        cur_reg      <= cur_next;
        cnt_reg      <= cnt_next;
        slot_reg     <= slot_next;
        m_grant_reg  <= m_grant_next;
        m_status_reg <= m_status_next;
    end

endmodule

`default_nettype wire

/* rtl/flsa_checker.sv */
// Port-level checker for free_list_slot_allocator, attached by bind.
// Uses flsa_pkg for widths and status codes.
`timescale 1ns / 1ps
`default_nettype none

module flsa_checker
    import flsa_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                cfg_valid,
    input wire logic                cfg_ready,
    input wire logic                cfg_safety,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                s_kind,
    input wire logic [SLOT_W-1:0]   s_slot,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [GRANT_W-1:0]  m_granted_slot,
    input wire logic [STATUS_W-1:0] m_status
);

    // init sweep keeps requests out right after reset
    a_init_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    // one request in flight: busy the cycle after acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted back to back");

    // only a successful allocate hands out a slot
    a_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_granted_slot == '0)
        else $error("nonzero slot on failed request");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted_slot) && $stable(m_status))
        else $error("result dropped or changed while stalled");

endmodule

bind free_list_slot_allocator flsa_checker u_flsa_checker (.*);

`default_nettype wire
